### rtl/record_bubble_sort_grouped_macros.svh
// Assertion macros for the record bubble sort block.
`ifndef RECORD_BUBBLE_SORT_GROUPED_MACROS_SVH
`define RECORD_BUBBLE_SORT_GROUPED_MACROS_SVH

`ifndef ASSERT_OFF
// Check that cons holds in the same cycle as ante.
`define RBSG_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rbsg same-cycle check failed");
// Check that cons holds in the cycle after ante.
`define RBSG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rbsg next-cycle check failed");
`else
`define RBSG_ASSERT_SAME(lbl, ante, cons)
`define RBSG_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/rbsg_pkg.sv
// Shared types and constants for the record bubble sort block.
package rbsg_pkg;

  localparam int MEM_BYTES        = 1024;
  localparam int MAX_RECORD_BYTES = 16;
  localparam int MAX_RECORDS      = 64;

  localparam int ADDR_W    = $clog2(MEM_BYTES);
  localparam int LEN_W     = 5;
  localparam int CNT_W     = 7;
  localparam int OFF_W     = 4;
  localparam int HOLD_W    = $clog2(MAX_RECORD_BYTES);
  localparam int PAPB_W    = 5;
  localparam int FETCH_N   = 6;
  localparam int STEP_W    = 3;

  typedef enum logic [1:0] {
    CMD_WRITE = 2'd0,
    CMD_SORT  = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [2:0] {
    REG_KEY_OFFSET    = 3'd0,
    REG_G1_USED       = 3'd1,
    REG_G1_OFFSET     = 3'd2,
    REG_G2_USED       = 3'd3,
    REG_G2_OFFSET     = 3'd4,
    REG_RECORD_BYTES  = 3'd5,
    REG_RECORD_COUNT  = 3'd6,
    REG_ASCENDING     = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_RDWAIT,
    S_PASS,
    S_FETCH,
    S_DECIDE,
    S_SAVE,
    S_COPY,
    S_REST,
    S_NEXT,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [OFF_W-1:0] key_offset;
    logic             first_group_used;
    logic [OFF_W-1:0] first_group_offset;
    logic             second_group_used;
    logic [OFF_W-1:0] second_group_offset;
    logic [LEN_W-1:0] record_bytes;
    logic [CNT_W-1:0] record_count;
    logic             ascending;
  } cfg_t;

  typedef struct packed {
    logic              valid;
    logic [1:0]        cmd;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } req_t;

  typedef struct packed {
    logic             valid;
    logic [7:0]       read_byte;
    logic [CNT_W-1:0] passes;
  } res_t;

endpackage

### rtl/record_bubble_sort_grouped.sv
// Write and unused commands load the result register in the cycle after acceptance; a
// read first passes the memory read register and S_RDWAIT. A sort makes passes of
// compares and swaps, each compare six reads through the single memory read port.
// Writes and unused commands go one per cycle unless the result stalls; reads and sorts
// hold off new requests until done. Reset clears the sequencer, out_valid and the
// configuration registers; record memory holds no reset value, undefined until written.
`include "record_bubble_sort_grouped_macros.svh"
module record_bubble_sort_grouped (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbsg_pkg::PAPB_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    command,
  input  logic [rbsg_pkg::ADDR_W-1:0]   byte_address,
  input  logic [7:0]                    write_byte,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [7:0]                    read_byte,
  output logic [rbsg_pkg::CNT_W-1:0]    passes_used
);
  import rbsg_pkg::*;

  cfg_t cfg;
  req_t req;
  res_t res;
  logic idle;
  logic accept;

  rbsg_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign in_stall = !idle || (out_valid && out_stall);
  assign accept   = in_valid && !in_stall;

  assign req.valid = accept;
  assign req.cmd   = command;
  assign req.addr  = byte_address;
  assign req.data  = write_byte;

  rbsg_sorter u_sorter (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .req  (req),
    .res  (res),
    .idle (idle)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res.valid) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      read_byte   <= res.read_byte;
      passes_used <= res.passes;
    end
  end

  `RBSG_ASSERT_SAME(a_res_slot_free, res.valid, !out_valid || !out_stall)
  `RBSG_ASSERT_NEXT(a_sort_busy, accept && (command == CMD_SORT), in_stall)
  `RBSG_ASSERT_SAME(a_one_kind, out_valid && (passes_used != '0), read_byte == 8'd0)

endmodule

### rtl/rbsg_regs.sv
// Configuration register file behind the APB-style port.
module rbsg_regs (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rbsg_pkg::PAPB_W-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output rbsg_pkg::cfg_t                cfg
);
  import rbsg_pkg::*;

  logic     wr;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign idx    = reg_idx_t'(paddr[PAPB_W-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.key_offset          <= '0;
      cfg.first_group_used    <= 1'b0;
      cfg.first_group_offset  <= '0;
      cfg.second_group_used   <= 1'b0;
      cfg.second_group_offset <= '0;
      cfg.record_bytes        <= LEN_W'(1);
      cfg.record_count        <= '0;
      cfg.ascending           <= 1'b1;
    end else if (wr) begin
      case (idx)
        REG_KEY_OFFSET:   cfg.key_offset          <= pwdata[OFF_W-1:0];
        REG_G1_USED:      cfg.first_group_used    <= pwdata[0];
        REG_G1_OFFSET:    cfg.first_group_offset  <= pwdata[OFF_W-1:0];
        REG_G2_USED:      cfg.second_group_used   <= pwdata[0];
        REG_G2_OFFSET:    cfg.second_group_offset <= pwdata[OFF_W-1:0];
        REG_RECORD_BYTES: cfg.record_bytes        <= pwdata[LEN_W-1:0];
        REG_RECORD_COUNT: cfg.record_count        <= pwdata[CNT_W-1:0];
        REG_ASCENDING:    cfg.ascending           <= pwdata[0];
        default:          ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      REG_KEY_OFFSET:   prdata = 32'(cfg.key_offset);
      REG_G1_USED:      prdata = 32'(cfg.first_group_used);
      REG_G1_OFFSET:    prdata = 32'(cfg.first_group_offset);
      REG_G2_USED:      prdata = 32'(cfg.second_group_used);
      REG_G2_OFFSET:    prdata = 32'(cfg.second_group_offset);
      REG_RECORD_BYTES: prdata = 32'(cfg.record_bytes);
      REG_RECORD_COUNT: prdata = 32'(cfg.record_count);
      REG_ASCENDING:    prdata = 32'(cfg.ascending);
      default:          prdata = '0;
    endcase
  end

endmodule

### rtl/rbsg_agu.sv
// Shared address adder: base plus byte offset, wrapping at the memory size.
module rbsg_agu (
  input  logic [rbsg_pkg::ADDR_W-1:0] base,
  input  logic [rbsg_pkg::LEN_W-1:0]  offset,
  output logic [rbsg_pkg::ADDR_W-1:0] sum
);
  import rbsg_pkg::*;

  assign sum = base + ADDR_W'(offset);

endmodule

### rtl/rbsg_sorter.sv
// Record memory with the command sequencer and the bubble sort engine.
module rbsg_sorter (
  input  logic           clk,
  input  logic           rst,
  input  rbsg_pkg::cfg_t cfg,
  input  rbsg_pkg::req_t req,
  output rbsg_pkg::res_t res,
  output logic           idle
);
  import rbsg_pkg::*;

  state_t state, state_next;

  logic [7:0] mem [MEM_BYTES];
  logic [7:0] rdata;
  logic [7:0] fetched [FETCH_N];
  logic [7:0] hold [MAX_RECORD_BYTES];

  logic [ADDR_W-1:0] a_base, b_base, rptr, wptr;
  logic [LEN_W-1:0]  cnt;
  logic [STEP_W-1:0] cstep;
  logic [CNT_W-1:0]  rem, passes;
  logic              swapped;

  logic [LEN_W-1:0]  len_eff;
  logic [CNT_W-1:0]  cnt_eff;
  logic [CNT_W:0]    passes_inc;
  logic [CNT_W-1:0]  rem_calc;
  logic [HOLD_W-1:0] hold_wr_idx;
  logic [STEP_W-1:0] slot;
  logic              grp_ok, out_of_order, do_swap;

  logic [ADDR_W-1:0] mem_raddr, mem_waddr;
  logic [7:0]        mem_wdata;
  logic              mem_we;
  logic [ADDR_W-1:0] agu_base, agu_sum;
  logic [LEN_W-1:0]  agu_off;

  rbsg_agu u_agu (
    .base   (agu_base),
    .offset (agu_off),
    .sum    (agu_sum)
  );

  always_comb begin
    if (cfg.record_bytes == '0) begin
      len_eff = LEN_W'(1);
    end else if (cfg.record_bytes > LEN_W'(MAX_RECORD_BYTES)) begin
      len_eff = LEN_W'(MAX_RECORD_BYTES);
    end else begin
      len_eff = cfg.record_bytes;
    end
    if (cfg.record_count > CNT_W'(MAX_RECORDS)) begin
      cnt_eff = CNT_W'(MAX_RECORDS);
    end else begin
      cnt_eff = cfg.record_count;
    end
  end

  assign passes_inc = {1'b0, passes} + (CNT_W+1)'(1);
  assign rem_calc   = ({1'b0, cnt_eff} > passes_inc) ?
                      CNT_W'({1'b0, cnt_eff} - passes_inc) : '0;
  assign hold_wr_idx = HOLD_W'(cnt - LEN_W'(1));
  assign slot        = cstep - STEP_W'(1);

  assign grp_ok = (!cfg.first_group_used  || (fetched[2] == fetched[3])) &&
                  (!cfg.second_group_used || (fetched[4] == fetched[5]));
  assign out_of_order = cfg.ascending ? (fetched[0] > fetched[1])
                                      : (fetched[0] < fetched[1]);
  assign do_swap = grp_ok && out_of_order;
  assign idle    = (state == S_IDLE);

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req.valid && (req.cmd == CMD_SORT)) begin
          state_next = S_PASS;
        end else if (req.valid && (req.cmd == CMD_READ)) begin
          state_next = S_RDWAIT;
        end
      end
      S_RDWAIT: state_next = S_IDLE;
      S_PASS:   state_next = (rem_calc == '0) ? S_DONE : S_FETCH;
      S_FETCH: begin
        if (cstep == STEP_W'(FETCH_N)) state_next = S_DECIDE;
      end
      S_DECIDE: state_next = do_swap ? S_SAVE : S_NEXT;
      S_SAVE: begin
        if (cnt == len_eff) state_next = S_COPY;
      end
      S_COPY: begin
        if (cnt == len_eff) state_next = S_REST;
      end
      S_REST: begin
        if ((cnt + LEN_W'(1)) == len_eff) state_next = S_NEXT;
      end
      S_NEXT: begin
        if (rem == CNT_W'(1)) begin
          state_next = swapped ? S_PASS : S_DONE;
        end else begin
          state_next = S_FETCH;
        end
      end
      S_DONE:  state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    mem_raddr = rptr;
    mem_we    = 1'b0;
    mem_waddr = wptr;
    mem_wdata = rdata;
    agu_base  = a_base;
    agu_off   = LEN_W'(cfg.key_offset);
    res       = '0;
    case (state)
      S_IDLE: begin
        mem_raddr = req.addr;
        mem_waddr = req.addr;
        mem_wdata = req.data;
        mem_we    = req.valid && (req.cmd == CMD_WRITE);
        res.valid = req.valid && (req.cmd != CMD_SORT) && (req.cmd != CMD_READ);
      end
      S_RDWAIT: begin
        res.valid     = 1'b1;
        res.read_byte = rdata;
      end
      S_FETCH: begin
        agu_base = cstep[0] ? b_base : a_base;
        case (cstep[2:1])
          2'd0:    agu_off = LEN_W'(cfg.key_offset);
          2'd1:    agu_off = LEN_W'(cfg.first_group_offset);
          default: agu_off = LEN_W'(cfg.second_group_offset);
        endcase
        mem_raddr = agu_sum;
      end
      S_COPY: begin
        mem_we = (cnt != '0);
      end
      S_REST: begin
        mem_we    = 1'b1;
        mem_wdata = hold[cnt[HOLD_W-1:0]];
      end
      S_NEXT: begin
        agu_base = b_base;
        agu_off  = len_eff;
      end
      S_DONE: begin
        res.valid  = 1'b1;
        res.passes = passes;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      passes <= '0;
    end else begin
      state <= state_next;
      if ((state == S_IDLE) && req.valid && (req.cmd == CMD_SORT)) begin
        passes <= '0;
      end else if ((state == S_PASS) && (rem_calc == '0)) begin
        passes <= passes_inc[CNT_W-1:0];
      end else if ((state == S_NEXT) && (rem == CNT_W'(1))) begin
        passes <= passes_inc[CNT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_PASS: begin
        a_base  <= '0;
        b_base  <= ADDR_W'(len_eff);
        rem     <= rem_calc;
        swapped <= 1'b0;
        cstep   <= '0;
      end
      S_FETCH: begin
        cstep <= cstep + STEP_W'(1);
        if (cstep != '0) fetched[slot] <= rdata;
      end
      S_DECIDE: begin
        rptr <= a_base;
        wptr <= a_base;
        cnt  <= '0;
        if (do_swap) swapped <= 1'b1;
      end
      S_SAVE: begin
        if (cnt < len_eff) rptr <= rptr + ADDR_W'(1);
        if (cnt != '0) hold[hold_wr_idx] <= rdata;
        cnt <= (cnt == len_eff) ? '0 : cnt + LEN_W'(1);
      end
      S_COPY: begin
        if (cnt < len_eff) rptr <= rptr + ADDR_W'(1);
        if (cnt != '0) wptr <= wptr + ADDR_W'(1);
        cnt <= (cnt == len_eff) ? '0 : cnt + LEN_W'(1);
      end
      S_REST: begin
        wptr <= wptr + ADDR_W'(1);
        cnt  <= cnt + LEN_W'(1);
      end
      S_NEXT: begin
        a_base <= b_base;
        b_base <= agu_sum;
        rem    <= rem - CNT_W'(1);
        cstep  <= '0;
      end
      default: ;
    endcase
  end

endmodule

### test/tb_record_bubble_sort_grouped.sv
`timescale 1ns / 1ps
// Testbench for record_bubble_sort_grouped: byte traffic and grouped sorts checked per transaction.
module tb_record_bubble_sort_grouped;
  import rbsg_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int TAIL_CYCLES = 20;
  localparam int ITEM_TARGET = 1600;
  localparam int PRINT_LIMIT = 40;

  typedef struct {
    logic [7:0]       read_byte;
    logic [CNT_W-1:0] passes;
  } readout_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [PAPB_W-1:0] paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        command;
  logic [ADDR_W-1:0] byte_address;
  logic [7:0]        write_byte;
  logic              out_valid;
  logic              out_stall;
  logic [7:0]        read_byte;
  logic [CNT_W-1:0]  passes_used;

  logic [7:0] record_image [MEM_BYTES];
  bit         written [MEM_BYTES];
  cfg_t       settings;
  readout_t   expected_readouts [$];

  int failures;
  int items_sent;
  int results_seen;
  int quiet_cycles;
  int hold_cycles;
  bit hold_request;
  bit sender_gaps;
  bit receiver_gaps;

  record_bubble_sort_grouped dut (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int layout_len();
    int len;
    len = settings.record_bytes;
    if (len < 1) len = 1;
    if (len > MAX_RECORD_BYTES) len = MAX_RECORD_BYTES;
    return len;
  endfunction

  function automatic int layout_count();
    int cnt;
    cnt = settings.record_count;
    if (cnt > MAX_RECORDS) cnt = MAX_RECORDS;
    return cnt;
  endfunction

  function automatic logic [7:0] image_at(input int addr);
    return record_image[addr % MEM_BYTES];
  endfunction

  // Sort the record image in place and return the passes made.
  function automatic int sorted_passes();
    int len, cnt, passes, a, b;
    bit swapped, same_group, out_of_order;
    logic [7:0] ka, kb;
    logic [7:0] saved [MAX_RECORD_BYTES];
    len = layout_len();
    cnt = layout_count();
    passes = 0;
    do begin
      swapped = 1'b0;
      for (int i = 0; i + 1 + passes < cnt; i++) begin
        a = len * i;
        b = a + len;
        ka = image_at(a + settings.key_offset);
        kb = image_at(b + settings.key_offset);
        same_group = 1'b1;
        if (settings.first_group_used &&
            image_at(a + settings.first_group_offset) !=
            image_at(b + settings.first_group_offset))
          same_group = 1'b0;
        if (settings.second_group_used &&
            image_at(a + settings.second_group_offset) !=
            image_at(b + settings.second_group_offset))
          same_group = 1'b0;
        out_of_order = settings.ascending ? (ka > kb) : (ka < kb);
        if (same_group && out_of_order) begin
          for (int k = 0; k < len; k++) saved[k] = image_at(a + k);
          for (int k = 0; k < len; k++) record_image[(a + k) % MEM_BYTES] = image_at(b + k);
          for (int k = 0; k < len; k++) record_image[(b + k) % MEM_BYTES] = saved[k];
          swapped = 1'b1;
        end
      end
      passes++;
    end while (swapped);
    return passes;
  endfunction

  function automatic readout_t predict_readout(input logic [1:0] cmd,
                                               input logic [ADDR_W-1:0] addr,
                                               input logic [7:0] data);
    readout_t r;
    r.read_byte = '0;
    r.passes = '0;
    case (cmd)
      CMD_WRITE: begin
        record_image[addr] = data;
        written[addr] = 1'b1;
      end
      CMD_SORT: r.passes = CNT_W'(sorted_passes());
      CMD_READ: r.read_byte = record_image[addr];
      default: ;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pick_byte(input bit narrow);
    return narrow ? 8'($urandom_range(0, 2)) : 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [OFF_W-1:0] pick_offset();
    if ($urandom_range(0, 3) == 0) return OFF_W'($urandom_range(0, 15));
    return OFF_W'($urandom_range(0, layout_len() - 1));
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    failures++;
    if (failures <= PRINT_LIMIT)
      $display("%0t: result %0d, %s: got %0h, expected %0h",
               $time, results_seen, what, got, want);
  endtask

  task automatic send_item(input logic [1:0] cmd, input int addr, input logic [7:0] data);
    int gap;
    if (sender_gaps && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 5);
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    command = cmd;
    byte_address = ADDR_W'(addr % MEM_BYTES);
    write_byte = data;
    do @(posedge clk); while (in_stall);
    expected_readouts.push_back(predict_readout(command, byte_address, write_byte));
    items_sent++;
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic read_written(input int addr);
    if (written[addr % MEM_BYTES]) send_item(CMD_READ, addr, pick_byte(1'b0));
  endtask

  task automatic wait_drained();
    while (expected_readouts.size() != 0) @(negedge clk);
  endtask

  task automatic write_register(input reg_idx_t idx, input logic [31:0] value);
    psel = 1'b1;
    penable = 1'b0;
    pwrite = 1'b1;
    paddr = {idx, 2'b00};
    pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    case (idx)
      REG_KEY_OFFSET:   settings.key_offset = value[OFF_W-1:0];
      REG_G1_USED:      settings.first_group_used = value[0];
      REG_G1_OFFSET:    settings.first_group_offset = value[OFF_W-1:0];
      REG_G2_USED:      settings.second_group_used = value[0];
      REG_G2_OFFSET:    settings.second_group_offset = value[OFF_W-1:0];
      REG_RECORD_BYTES: settings.record_bytes = value[LEN_W-1:0];
      REG_RECORD_COUNT: settings.record_count = value[CNT_W-1:0];
      REG_ASCENDING:    settings.ascending = value[0];
      default: ;
    endcase
  endtask

  task automatic program_layout(input int key, input int g1_used, input int g1_off,
                                input int g2_used, input int g2_off, input int bytes,
                                input int count, input int asc);
    write_register(REG_KEY_OFFSET, key);
    write_register(REG_G1_USED, g1_used);
    write_register(REG_G1_OFFSET, g1_off);
    write_register(REG_G2_USED, g2_used);
    write_register(REG_G2_OFFSET, g2_off);
    write_register(REG_RECORD_BYTES, bytes);
    write_register(REG_RECORD_COUNT, count);
    write_register(REG_ASCENDING, asc);
  endtask

  // Write every byte that the next sort can touch and that holds no data yet.
  task automatic write_missing_for_sort();
    int len, cnt, reach, addr;
    len = layout_len();
    cnt = layout_count();
    reach = (len > MAX_RECORD_BYTES - 1) ? len : MAX_RECORD_BYTES;
    if (cnt >= 2) begin
      for (int r = 0; r < cnt; r++) begin
        for (int k = 0; k < reach; k++) begin
          addr = (r * len + k) % MEM_BYTES;
          if (!written[addr]) send_item(CMD_WRITE, addr, pick_byte(1'b0));
        end
      end
    end
  endtask

  task automatic test_directed();
    send_item(CMD_WRITE, 0, 8'h00);
    send_item(CMD_WRITE, MEM_BYTES - 1, 8'hFF);
    send_item(CMD_READ, MEM_BYTES - 1, 8'h00);
    send_item(CMD_READ, 0, 8'hFF);
    send_item(CMD_UNUSED, 'h2AA, 8'h55);
    send_item(CMD_SORT, 'h155, 8'hAA);
    wait_drained();
    write_register(REG_RECORD_COUNT, 1);
    send_item(CMD_SORT, 0, 8'h00);
    wait_drained();
    write_register(REG_RECORD_COUNT, 3);
    write_register(REG_ASCENDING, 0);
    send_item(CMD_WRITE, 0, 8'h10);
    send_item(CMD_WRITE, 1, 8'hFF);
    send_item(CMD_WRITE, 2, 8'h00);
    send_item(CMD_SORT, 0, 8'h00);
    for (int a = 0; a < 3; a++) send_item(CMD_READ, a, 8'h00);
    wait_drained();
  endtask

  task automatic test_extreme_layouts();
    for (int a = 0; a < MEM_BYTES; a++)
      send_item(CMD_WRITE, a, pick_byte($urandom_range(0, 3) == 0));
    wait_drained();
    program_layout(15, 0, 0, 0, 15, 31, 127, 0);
    send_item(CMD_SORT, 0, 8'h00);
    repeat (16) read_written($urandom_range(0, MEM_BYTES - 1));
    wait_drained();
    program_layout(0, 1, 15, 0, 0, 0, 64, 1);
    send_item(CMD_SORT, MEM_BYTES - 1, 8'hFF);
    repeat (8) read_written($urandom_range(0, 79));
    wait_drained();
    program_layout(15, 1, 0, 1, 14, 16, 64, 1);
    send_item(CMD_SORT, 0, 8'h00);
    repeat (8) read_written($urandom_range(0, MEM_BYTES - 1));
    wait_drained();
    write_register(REG_RECORD_COUNT, 1);
    send_item(CMD_SORT, 0, 8'h00);
    wait_drained();
  endtask

  task automatic test_random_sorts(input int target);
    int kind, span, n, addr;
    bit narrow;
    while (items_sent < target) begin
      wait_drained();
      write_register(REG_RECORD_BYTES,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : $urandom_range(1, 6));
      write_register(REG_RECORD_COUNT,
                     ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 12));
      write_register(REG_KEY_OFFSET, 32'(pick_offset()));
      write_register(REG_G1_USED, $urandom_range(0, 1));
      write_register(REG_G1_OFFSET, 32'(pick_offset()));
      write_register(REG_G2_USED, $urandom_range(0, 1));
      write_register(REG_G2_OFFSET, 32'(pick_offset()));
      write_register(REG_ASCENDING, $urandom_range(0, 1));
      span = layout_len() * layout_count() + MAX_RECORD_BYTES;
      if (span > MEM_BYTES) span = MEM_BYTES;
      write_missing_for_sort();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(6, 16)) begin
          n = $urandom_range(0, 9);
          addr = $urandom_range(0, MEM_BYTES - 1);
          if (n < 4) send_item(CMD_WRITE, addr, pick_byte(1'b0));
          else if (n < 7) read_written(addr);
          else if (n < 9) send_item(CMD_UNUSED, addr, pick_byte(1'b0));
          else begin
            write_missing_for_sort();
            send_item(CMD_SORT, addr, pick_byte(1'b0));
          end
        end
      end else begin
        if (kind != 1) begin
          narrow = $urandom_range(0, 1);
          repeat ($urandom_range(4, 24))
            send_item(CMD_WRITE, $urandom_range(0, span - 1), pick_byte(narrow));
        end
        send_item(CMD_SORT, $urandom_range(0, MEM_BYTES - 1), pick_byte(1'b0));
        if (kind == 1) send_item(CMD_SORT, 0, 8'h00);
        repeat ($urandom_range(2, 8)) read_written($urandom_range(0, span - 1));
      end
    end
    wait_drained();
  endtask

  task automatic test_stalled_receiver();
    wait_drained();
    hold_cycles = 200;
    hold_request = 1'b1;
    repeat (12) begin
      send_item(CMD_WRITE, $urandom_range(0, MEM_BYTES - 1), pick_byte(1'b0));
      read_written($urandom_range(0, MEM_BYTES - 1));
    end
    wait_drained();
    write_register(REG_RECORD_COUNT, 10);
    write_register(REG_RECORD_BYTES, 3);
    write_missing_for_sort();
    hold_cycles = 120;
    hold_request = 1'b1;
    send_item(CMD_SORT, 0, 8'h00);
    repeat (6) read_written($urandom_range(0, 29));
    wait_drained();
  endtask

  // Receiver side: random stall bursts and requested long hold-offs.
  initial begin
    int burst;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_stall = 1'b1;
        repeat (hold_cycles) @(negedge clk);
        out_stall = 1'b0;
        hold_request = 1'b0;
      end else if (receiver_gaps && $urandom_range(0, 9) == 0) begin
        burst = $urandom_range(1, 5);
        out_stall = 1'b1;
        repeat (burst) @(negedge clk);
        out_stall = 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    readout_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_readouts.size() == 0) begin
        report_mismatch("unexpected transaction", {24'h0, read_byte}, 32'h0);
      end else begin
        want = expected_readouts.pop_front();
        if (read_byte !== want.read_byte)
          report_mismatch("read_byte", 32'(read_byte), 32'(want.read_byte));
        if (passes_used !== want.passes)
          report_mismatch("passes_used", 32'(passes_used), 32'(want.passes));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  initial begin
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid = 1'b0;
    command = CMD_WRITE;
    byte_address = '0;
    write_byte = '0;
    sender_gaps = 1'b1;
    receiver_gaps = 1'b1;
    hold_request = 1'b0;
    hold_cycles = 0;
    settings = '0;
    settings.record_bytes = 1;
    settings.ascending = 1'b1;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_extreme_layouts();
    test_random_sorts(ITEM_TARGET - 200);
    test_stalled_receiver();
    sender_gaps = 1'b0;
    receiver_gaps = 1'b0;
    test_random_sorts(ITEM_TARGET);
    wait_drained();
    repeat (TAIL_CYCLES) @(negedge clk);
    if (failures == 0 && expected_readouts.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
